// ===== rtl/core/ffsc_pkg.sv =====
// Shared types, widths and codes for the farthest-from-selection slot cache.
`default_nettype none
package ffsc_pkg;

  localparam int ITEM_W     = 10;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int SLOT_W     = 6;
  localparam int CFG_W      = 7;
  localparam int SLOTS_DEF  = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_EVICT  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STS_PLACED   = 2'd0;
  localparam logic [STATUS_W-1:0] STS_REPLACED = 2'd1;
  localparam logic [STATUS_W-1:0] STS_HIT      = 2'd2;
  localparam logic [STATUS_W-1:0] STS_MISS     = 2'd3;

  typedef struct packed {
    logic [ITEM_W-1:0] gap;
    logic              farther;
  } dist_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/ffsc_dist.sv =====
// Shared distance unit: absolute distance to the selection and compare against the best so far.
`default_nettype none
module ffsc_dist (
  input  wire logic [ffsc_pkg::ITEM_W-1:0] occupant,
  input  wire logic [ffsc_pkg::ITEM_W-1:0] selection,
  input  wire logic [ffsc_pkg::ITEM_W-1:0] best,
  output ffsc_pkg::dist_res_t              res
);
  import ffsc_pkg::*;

  logic [ITEM_W-1:0] gap;

  assign gap         = (occupant >= selection) ? (occupant - selection) : (selection - occupant);
  assign res.gap     = gap;
  assign res.farther = (gap > best);

endmodule
`default_nettype wire

// ===== rtl/core/farthest_from_selection_slot_cache.sv =====
// Top level of the farthest-from-selection slot cache.
// Each item scans the active slots one per cycle through a single distance unit.
// The result is registered in the finishing step after the scan of the active slots.
// A new item is taken only in the idle state, once the last item's result has been registered.
// Synchronous active-low reset empties every slot and sets the slot count to 64.
`default_nettype none
module farthest_from_selection_slot_cache #(
  parameter int SLOTS = ffsc_pkg::SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [ffsc_pkg::CFG_W-1:0]    cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ffsc_pkg::ACTION_W-1:0] in_action,
  input  wire logic [ffsc_pkg::ITEM_W-1:0]   in_item_index,
  input  wire logic [ffsc_pkg::ITEM_W-1:0]   in_selection,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ffsc_pkg::STATUS_W-1:0]      out_status,
  output logic [ffsc_pkg::SLOT_W-1:0]        out_slot,
  output logic                               out_evicted_valid,
  output logic [ffsc_pkg::ITEM_W-1:0]        out_evicted_item
);
  import ffsc_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t               state_r;
  logic [CFG_W-1:0]     slots_in_use_r;
  logic [SLOTS-1:0]     slot_full_r;
  logic [ITEM_W-1:0]    slot_item_mem [SLOTS];

  logic [ACTION_W-1:0]  act_r;
  logic [ITEM_W-1:0]    item_r;
  logic [ITEM_W-1:0]    sel_r;
  logic [CW-1:0]        n_r;
  logic [CW-1:0]        issue_r;
  logic                 p_vld_r;
  logic [IW-1:0]        p_idx_r;
  logic [ITEM_W-1:0]    rdata_r;

  logic                 any_r;
  logic [ITEM_W-1:0]    best_r;
  logic [IW-1:0]        where_r;
  logic [ITEM_W-1:0]    best_item_r;
  logic                 emp_found_r;
  logic [IW-1:0]        emp_idx_r;
  logic                 hit_r;
  logic [IW-1:0]        hit_idx_r;

  logic                 out_valid_r;
  logic [STATUS_W-1:0]  out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_ev_valid_r;
  logic [ITEM_W-1:0]    out_ev_item_r;

  logic [NW-1:0]        n_ext;
  logic [CW-1:0]        n_nxt;
  logic                 issuing;
  logic                 p_full;
  dist_res_t            dres;
  logic                 out_free;

  logic [STATUS_W-1:0]  res_status;
  logic [IW-1:0]        tgt_idx;
  logic [IW+SLOT_W-1:0] tgt_ext;
  logic                 res_ev_valid;
  logic [ITEM_W-1:0]    res_ev_item;
  logic                 wr_en;
  logic                 full_set;
  logic                 full_clr;

  // Active slot count, with zero taken as one and values above the table size clamped.
  always_comb begin
    n_ext = NW'(slots_in_use_r);
    if (n_ext == '0) begin
      n_nxt = CW'(1);
    end else if (n_ext > NW'(SLOTS)) begin
      n_nxt = CW'(SLOTS);
    end else begin
      n_nxt = n_ext[CW-1:0];
    end
  end

  assign issuing  = (state_r == ST_SCAN) && (issue_r < n_r);
  assign p_full   = slot_full_r[p_idx_r];
  assign out_free = !out_valid_r || !out_stall;

  ffsc_dist u_dist (
    .occupant  (rdata_r),
    .selection (sel_r),
    .best      (best_r),
    .res       (dres)
  );

  always_comb begin
    res_status   = STS_MISS;
    tgt_idx      = '0;
    res_ev_valid = 1'b0;
    res_ev_item  = '0;
    wr_en        = 1'b0;
    full_set     = 1'b0;
    full_clr     = 1'b0;
    unique case (act_r)
      ACT_INSERT: begin
        if (emp_found_r) begin
          res_status = STS_PLACED;
          tgt_idx    = emp_idx_r;
          wr_en      = 1'b1;
          full_set   = 1'b1;
        end else if (any_r) begin
          res_status   = STS_REPLACED;
          tgt_idx      = where_r;
          wr_en        = 1'b1;
          res_ev_valid = 1'b1;
          res_ev_item  = best_item_r;
        end
      end
      ACT_EVICT: begin
        if (any_r) begin
          res_status   = STS_HIT;
          tgt_idx      = where_r;
          full_clr     = 1'b1;
          res_ev_valid = 1'b1;
          res_ev_item  = best_item_r;
        end
      end
      ACT_LOOKUP: begin
        if (hit_r) begin
          res_status = STS_HIT;
          tgt_idx    = hit_idx_r;
        end
      end
      default: begin
        res_status = STS_MISS;
      end
    endcase
  end

  assign tgt_ext = {{SLOT_W{1'b0}}, tgt_idx};

  always_ff @(posedge clk) begin
    if (issuing) begin
      rdata_r <= slot_item_mem[issue_r[IW-1:0]];
    end
    if (state_r == ST_FINISH && out_free && wr_en) begin
      slot_item_mem[tgt_idx] <= item_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      slots_in_use_r <= CFG_RESET;
      slot_full_r    <= '0;
      p_vld_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use_r <= cfg_wdata;
      end
      if (out_valid_r && !out_stall && state_r != ST_FINISH) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          p_vld_r <= 1'b0;
          if (in_valid) begin
            act_r       <= in_action;
            item_r      <= in_item_index;
            sel_r       <= in_selection;
            n_r         <= n_nxt;
            issue_r     <= '0;
            any_r       <= 1'b0;
            best_r      <= '0;
            where_r     <= '0;
            best_item_r <= '0;
            emp_found_r <= 1'b0;
            emp_idx_r   <= '0;
            hit_r       <= 1'b0;
            hit_idx_r   <= '0;
            state_r     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            p_vld_r <= 1'b1;
            p_idx_r <= issue_r[IW-1:0];
            issue_r <= issue_r + CW'(1);
          end else begin
            p_vld_r <= 1'b0;
            if (!p_vld_r) begin
              state_r <= ST_FINISH;
            end
          end
          if (p_vld_r) begin
            if (p_full) begin
              if (!any_r || dres.farther) begin
                any_r       <= 1'b1;
                best_r      <= dres.gap;
                where_r     <= p_idx_r;
                best_item_r <= rdata_r;
              end
              if (rdata_r == item_r) begin
                hit_r     <= 1'b1;
                hit_idx_r <= p_idx_r;
              end
            end else if (!emp_found_r) begin
              emp_found_r <= 1'b1;
              emp_idx_r   <= p_idx_r;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            if (full_set) begin
              slot_full_r[tgt_idx] <= 1'b1;
            end
            if (full_clr) begin
              slot_full_r[tgt_idx] <= 1'b0;
            end
            out_valid_r    <= 1'b1;
            out_status_r   <= res_status;
            out_slot_r     <= tgt_ext[SLOT_W-1:0];
            out_ev_valid_r <= res_ev_valid;
            out_ev_item_r  <= res_ev_item;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_item  = out_ev_item_r;

`ifndef NO_ASSERTIONS
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("Result raised outside the finishing step.");

  a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ev_valid_r) |->
      (out_status_r == STS_REPLACED || out_status_r == STS_HIT))
    else $error("Evicted item reported with an unrelated status.");

  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == STS_MISS) |->
      (out_slot_r == '0 && !out_ev_valid_r && out_ev_item_r == '0))
    else $error("Miss result carries non-zero fields.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (issue_r <= n_r && n_r != '0))
    else $error("Slot scan ran past the active slot count.");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/farthest_from_selection_slot_cache_test.sv =====
// Self-checking testbench for the farthest-from-selection slot cache.
`timescale 1ns / 100ps
module farthest_from_selection_slot_cache_test;
  import ffsc_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASES = 13;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                ev_valid;
    logic [ITEM_W-1:0]   ev_item;
  } slot_result_t;

  typedef struct {
    bit                  is_cfg;
    logic [CFG_W-1:0]    count;
    logic [ACTION_W-1:0] act;
    logic [ITEM_W-1:0]   item;
    logic [ITEM_W-1:0]   sel;
    bit                  typed;
    slot_result_t        want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action;
  logic [ITEM_W-1:0]   in_item_index;
  logic [ITEM_W-1:0]   in_selection;
  logic                out_valid;
  logic                out_stall;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_evicted_valid;
  logic [ITEM_W-1:0]   out_evicted_item;

  bit               slot_taken [SLOTS_DEF];
  logic [ITEM_W-1:0] slot_entry [SLOTS_DEF];
  logic [CFG_W-1:0] slot_count;
  slot_result_t     pending_results [$];
  plan_row_t        plan [$];

  int phase_slots [PHASES] = '{4, 1, 0, 2, 64, 8, 127, 3, 100, 16, 5, 64, 2};
  int phase_items [PHASES] = '{120, 60, 40, 100, 200, 120, 140, 100, 120, 120, 80, 150, 80};

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_written = 0;
  int cycle_count = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  bit quiet = 1'b0;

  farthest_from_selection_slot_cache DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_item_index     (in_item_index),
    .in_selection      (in_selection),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_item  (out_evicted_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int active_slots();
    if (slot_count == 0) return 1;
    if (slot_count > SLOTS_DEF) return SLOTS_DEF;
    return int'(slot_count);
  endfunction

  function automatic slot_result_t predict_request(input logic [ACTION_W-1:0] act,
                                                   input logic [ITEM_W-1:0] item,
                                                   input logic [ITEM_W-1:0] sel);
    slot_result_t r;
    int n, i, far, empty;
    logic [ITEM_W-1:0] best, d;
    r = '0;
    r.status = STS_MISS;
    n = active_slots();
    far = -1;
    empty = -1;
    best = '0;
    for (i = 0; i < n; i++) begin
      if (slot_taken[i]) begin
        d = (slot_entry[i] >= sel) ? slot_entry[i] - sel : sel - slot_entry[i];
        if (far < 0 || d > best) begin
          far = i;
          best = d;
        end
      end else if (empty < 0) begin
        empty = i;
      end
    end
    case (act)
      ACT_INSERT: begin
        if (empty >= 0) begin
          slot_taken[empty] = 1'b1;
          slot_entry[empty] = item;
          r.status = STS_PLACED;
          r.slot = SLOT_W'(empty);
        end else begin
          r.status = STS_REPLACED;
          r.slot = SLOT_W'(far);
          r.ev_valid = 1'b1;
          r.ev_item = slot_entry[far];
          slot_entry[far] = item;
        end
      end
      ACT_EVICT: begin
        if (far >= 0) begin
          r.status = STS_HIT;
          r.slot = SLOT_W'(far);
          r.ev_valid = 1'b1;
          r.ev_item = slot_entry[far];
          slot_taken[far] = 1'b0;
        end
      end
      ACT_LOOKUP: begin
        for (i = 0; i < n; i++) begin
          if (slot_taken[i] && slot_entry[i] == item) begin
            r.status = STS_HIT;
            r.slot = SLOT_W'(i);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [ITEM_W-1:0] resident_item();
    logic [ITEM_W-1:0] pool [$];
    int i;
    for (i = 0; i < active_slots(); i++) begin
      if (slot_taken[i]) pool.push_back(slot_entry[i]);
    end
    if (pool.size() == 0) return ITEM_W'($urandom_range(0, 1023));
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  function automatic logic [ITEM_W-1:0] random_item();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return ITEM_W'($urandom_range(0, 1023));
      4, 5, 6: return ITEM_W'($urandom_range(0, 15));
      7: return 10'd1023 - ITEM_W'($urandom_range(0, 7));
      default: return resident_item();
    endcase
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors <= 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endfunction

  task automatic plan_req(input bit typed, input logic [ACTION_W-1:0] act,
                          input logic [ITEM_W-1:0] item, input logic [ITEM_W-1:0] sel,
                          input logic [STATUS_W-1:0] st, input logic [SLOT_W-1:0] slot,
                          input logic evv, input logic [ITEM_W-1:0] evi);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.count = '0;
    row.act = act;
    row.item = item;
    row.sel = sel;
    row.typed = typed;
    row.want.status = st;
    row.want.slot = slot;
    row.want.ev_valid = evv;
    row.want.ev_item = evi;
    plan.push_back(row);
  endtask

  task automatic plan_count(input logic [CFG_W-1:0] value);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.count = value;
    row.act = ACT_INSERT;
    row.item = '0;
    row.sel = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan.push_back(row);
  endtask

  task automatic offer(input logic [ACTION_W-1:0] act, input logic [ITEM_W-1:0] item,
                       input logic [ITEM_W-1:0] sel, input bit typed,
                       input slot_result_t want);
    slot_result_t predicted;
    in_valid <= 1'b1;
    in_action <= act;
    in_item_index <= item;
    in_selection <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_request(act, item, sel);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic maybe_pause(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic set_slot_count(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    slot_count = value;
    settings_written++;
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count,
               pending_results.size());
      $display("** farthest_from_selection_slot_cache: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    slot_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                 $time, out_status, out_slot);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("slot", want.slot, out_slot);
        compare_field("evicted_valid", want.ev_valid, out_evicted_valid);
        compare_field("evicted_item", want.ev_item, out_evicted_item);
        status_seen[want.status]++;
      end
    end
  end

  // The receiver stalls in short random bursts and twice holds off long enough to back up the input.
  initial begin
    int left, pct, tick, hold_mark;
    left = 0;
    pct = 12;
    tick = 0;
    hold_mark = 300;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (tick % 256 == 0) pct = $urandom_range(0, 3) * 12;
      if (left == 0) begin
        if (results_seen >= hold_mark) begin
          left = HOLD_CYCLES;
          hold_mark += 880;
        end else if (!quiet && $urandom_range(0, 99) < pct) begin
          left = $urandom_range(1, 7);
        end
      end
      out_stall <= (left != 0);
      if (left != 0) left--;
    end
  end

  initial begin
    int i, p, pct;
    logic [ACTION_W-1:0] act;
    logic [ITEM_W-1:0] item, sel;
    int r;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= CFG_RESET;
    in_valid <= 1'b0;
    in_action <= ACT_INSERT;
    in_item_index <= '0;
    in_selection <= '0;
    for (i = 0; i < SLOTS_DEF; i++) begin
      slot_taken[i] = 1'b0;
      slot_entry[i] = '0;
    end
    slot_count = CFG_RESET;

    plan_req(1, ACT_EVICT, 0, 0, STS_MISS, 0, 0, 0);
    plan_req(1, ACT_LOOKUP, 5, 0, STS_MISS, 0, 0, 0);
    plan_req(1, ACT_UNUSED, 1023, 1023, STS_MISS, 0, 0, 0);
    plan_req(1, ACT_INSERT, 1023, 0, STS_PLACED, 0, 0, 0);
    plan_req(1, ACT_INSERT, 0, 1023, STS_PLACED, 1, 0, 0);
    plan_req(1, ACT_LOOKUP, 1023, 0, STS_HIT, 0, 0, 0);
    plan_count(2);
    plan_req(1, ACT_INSERT, 512, 0, STS_REPLACED, 0, 1, 1023);
    plan_req(1, ACT_INSERT, 7, 1023, STS_REPLACED, 1, 1, 0);
    plan_req(1, ACT_EVICT, 0, 7, STS_HIT, 0, 1, 512);
    plan_req(1, ACT_INSERT, 7, 0, STS_PLACED, 0, 0, 0);
    plan_req(1, ACT_LOOKUP, 7, 0, STS_HIT, 1, 0, 0);
    plan_req(1, ACT_EVICT, 0, 7, STS_HIT, 0, 1, 7);
    plan_count(0);
    plan_req(1, ACT_LOOKUP, 7, 0, STS_MISS, 0, 0, 0);
    plan_req(1, ACT_INSERT, 300, 0, STS_PLACED, 0, 0, 0);
    plan_req(1, ACT_INSERT, 301, 0, STS_REPLACED, 0, 1, 300);
    plan_req(1, ACT_EVICT, 0, 301, STS_HIT, 0, 1, 301);
    plan_req(1, ACT_EVICT, 0, 0, STS_MISS, 0, 0, 0);
    plan_count(127);
    plan_req(1, ACT_LOOKUP, 7, 0, STS_HIT, 1, 0, 0);
    plan_req(1, ACT_INSERT, 1000, 1000, STS_PLACED, 0, 0, 0);
    plan_req(1, ACT_INSERT, 1000, 1000, STS_PLACED, 2, 0, 0);
    plan_req(1, ACT_EVICT, 0, 1000, STS_HIT, 1, 1, 7);
    plan_count(3);
    plan_req(0, ACT_INSERT, 511, 512, STS_MISS, 0, 0, 0);
    plan_req(0, ACT_LOOKUP, 1000, 0, STS_MISS, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < plan.size(); i++) begin
      if (plan[i].is_cfg) begin
        set_slot_count(plan[i].count);
      end else begin
        offer(plan[i].act, plan[i].item, plan[i].sel, plan[i].typed, plan[i].want);
        maybe_pause(20);
      end
    end

    for (p = 0; p < PHASES; p++) begin
      set_slot_count(CFG_W'(phase_slots[p]));
      quiet = (p == PHASES - 1);
      pct = quiet ? 0 : $urandom_range(0, 2) * 15;
      repeat (phase_items[p]) begin
        r = $urandom_range(0, 99);
        if (r < (active_slots() > 32 ? 60 : 45)) act = ACT_INSERT;
        else if (r < 70) act = ACT_EVICT;
        else if (r < 96) act = ACT_LOOKUP;
        else act = ACT_UNUSED;
        case ($urandom_range(0, 5))
          0: sel = resident_item();
          1: sel = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          default: sel = ITEM_W'($urandom_range(0, 1023));
        endcase
        if (act == ACT_LOOKUP && $urandom_range(0, 4) < 3) item = resident_item();
        else item = random_item();
        offer(act, item, sel, 1'b0, '0);
        maybe_pause(pct);
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * SLOTS_DEF) @(posedge clk);

    $display("Run covered %0d items across %0d slot-count settings, zero and oversized counts",
             items_sent, settings_written);
    $display("included; results: %0d placed, %0d replaced, %0d found or evicted, %0d missed.",
             status_seen[STS_PLACED], status_seen[STS_REPLACED], status_seen[STS_HIT],
             status_seen[STS_MISS]);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("** farthest_from_selection_slot_cache: PASSED **");
    end else begin
      $display("** farthest_from_selection_slot_cache: FAILED **");
    end
    $finish;
  end

endmodule
